### rtl/fbd_pkg.sv
`timescale 1ns / 1ps

package fbd_pkg;

    localparam int PCLK_W     = 27;
    localparam int BAUD_W     = 23;
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 28;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int DL_W       = 16;
    localparam int FRAC_W     = 4;
    localparam int SUM_W      = FRAC_W + 1;
    localparam int PM_W       = PCLK_W + FRAC_W;
    localparam int RDEN_W     = DL_W + SUM_W + 3;

    localparam logic [PCLK_W-1:0] PCLK_RESET = PCLK_W'(100000000);
    localparam logic [FRAC_W-1:0] MUL_LAST   = 4'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_GO,
        ST_P_WAIT,
        ST_C_MUL,
        ST_D1_GO,
        ST_D1_WAIT,
        ST_C_DL,
        ST_D2_GO,
        ST_D2_WAIT,
        ST_EVAL,
        ST_OUT
    } fbd_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

### rtl/fractional_baud_divider_search_unit.sv
`timescale 1ns / 1ps

// Fractional baud rate divider search.
// cfg_valid/cfg_ready/cfg_data write the peripheral clock frequency in hertz;
// cfg_ready is always high, and the value should change only while idle.
// A transfer on s_tvalid/s_tready carries a requested baud rate. The unit then
// answers with one transfer on m_tvalid/m_tready: the 16-bit divisor latch value
// and the fractional multiplier and add value, with m_tuser set when the
// requested rate was zero and no setting is produced.
// All divisions go through one 32-bit restoring divider. When the clock divides
// evenly by sixteen times the rate, the result is offered once the first
// division is done. Otherwise 120 candidate pairs are tried, each with two
// divisions plus the setup and compare states ST_C_MUL, ST_C_DL and ST_EVAL.
// A zero rate is offered in the cycle right after its transfer.
// s_tready is low from the accepted transfer until the result has been taken, and
// the next transfer can be accepted in the cycle after that; a stalled receiver
// simply holds the result in m_tdata.
// Reset restores the clock register to 100 MHz and returns the unit to idle.
module fractional_baud_divider_search_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [26:0] cfg_data,    // pclk_hz
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [22:0] requested rate, [23] zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [15:0] divisor_latch, [19:16] mul_val,
                                     // [23:20] div_add_val
    output logic        m_tuser      // [0] unchanged
);
    import fbd_pkg::*;

    fbd_state_t state_reg, state_next;

    logic [PCLK_W-1:0]    pclk_reg;
    logic [BAUD_W-1:0]    baud_reg, baud_next;
    logic [FRAC_W-1:0]    mv_reg, mv_next;
    logic [FRAC_W-1:0]    dav_reg, dav_next;
    logic [PM_W-1:0]      pm_reg, pm_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic                 wide_reg, wide_next;
    logic [DL_W-1:0]      dl_reg, dl_next;
    logic [RDEN_W-1:0]    rden_reg, rden_next;
    logic [BAUD_W-1:0]    best_err_reg, best_err_next;
    logic [DL_W-1:0]      dl_best_reg, dl_best_next;
    logic [FRAC_W-1:0]    mul_best_reg, mul_best_next;
    logic [FRAC_W-1:0]    add_best_reg, add_best_next;
    logic                 unch_reg, unch_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                  s_fire;
    logic                  m_fire;
    logic [SUM_W-1:0]      frac_sum;
    logic                  last_pair;
    logic [DIVIDEND_W-4:0] q_round;
    logic [DL_W-1:0]       dl_raw;
    logic [DIVIDEND_W:0]   rate_x2;
    logic [DIVIDEND_W-1:0] rate;
    logic [DIVIDEND_W-1:0] err;

    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign frac_sum  = SUM_W'(mv_reg) + SUM_W'(dav_reg);
    assign last_pair = (dav_reg == mv_reg - 1'b1);

    // The divisor is the rounded quotient scaled down by 64 (32 when the doubled
    // clock product already reaches bit 31), truncated to 16 bits.
    always_comb begin
        if (wide_reg) begin
            q_round = {1'b0, div_rsp.quotient[DIVIDEND_W-1:4]} + 1'b1;
        end else begin
            q_round = {2'b00, div_rsp.quotient[DIVIDEND_W-1:5]} + 1'b1;
        end
        dl_raw = q_round[DL_W:1];
    end

    assign rate_x2 = {1'b0, div_rsp.quotient} + 1'b1;
    assign rate    = rate_x2[DIVIDEND_W:1];
    assign err     = (rate > DIVIDEND_W'(baud_reg)) ? rate - DIVIDEND_W'(baud_reg)
                                                    : DIVIDEND_W'(baud_reg) - rate;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tdata[BAUD_W-1:0] == '0) ? ST_OUT : ST_P_GO;
                end
            end
            ST_P_GO:    state_next = ST_P_WAIT;
            ST_P_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (div_rsp.remainder == '0) ? ST_OUT : ST_C_MUL;
                end
            end
            ST_C_MUL:   state_next = ST_D1_GO;
            ST_D1_GO:   state_next = ST_D1_WAIT;
            ST_D1_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_C_DL;
                end
            end
            ST_C_DL:    state_next = ST_D2_GO;
            ST_D2_GO:   state_next = ST_D2_WAIT;
            ST_D2_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = (last_pair && mv_reg == MUL_LAST) ? ST_OUT : ST_C_MUL;
            end
            ST_OUT: begin
                if (m_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Handshake and divider operand selection.
    always_comb begin
        s_tready         = 1'b0;
        m_tvalid         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_OUT:  m_tvalid = 1'b1;
            ST_P_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(pclk_reg);
                div_req.divisor  = {1'b0, baud_reg, 4'b0000};
            end
            ST_D1_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = wide_reg ? {pm_reg[PM_W-1:0], 1'b0}
                                            : {pm_reg[PM_W-2:0], 2'b00};
                div_req.divisor  = den_reg;
            end
            ST_D2_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(pm_reg);
                div_req.divisor  = DIVISOR_W'(rden_reg);
            end
            default: ;
        endcase
    end

    // Datapath registers.
    always_comb begin
        baud_next     = baud_reg;
        mv_next       = mv_reg;
        dav_next      = dav_reg;
        pm_next       = pm_reg;
        den_next      = den_reg;
        wide_next     = wide_reg;
        dl_next       = dl_reg;
        rden_next     = rden_reg;
        best_err_next = best_err_reg;
        dl_best_next  = dl_best_reg;
        mul_best_next = mul_best_reg;
        add_best_next = add_best_reg;
        unch_next     = unch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                baud_next     = s_tdata[BAUD_W-1:0];
                dl_best_next  = '0;
                mul_best_next = 4'd1;
                add_best_next = '0;
                unch_next     = (s_tdata[BAUD_W-1:0] == '0);
            end
            ST_P_WAIT: begin
                dl_best_next  = div_rsp.quotient[DL_W-1:0];
                best_err_next = baud_reg;
                mv_next       = 4'd1;
                dav_next      = '0;
            end
            ST_C_MUL: begin
                pm_next   = PM_W'(pclk_reg) * PM_W'(mv_reg);
                den_next  = DIVISOR_W'(baud_reg) * DIVISOR_W'(frac_sum);
                wide_next = pm_next[PM_W-1];
            end
            ST_D1_WAIT: begin
                if (dav_reg != '0 && dl_raw < DL_W'(2)) begin
                    dl_next = DL_W'(2);
                end else if (dl_raw == '0) begin
                    dl_next = DL_W'(1);
                end else begin
                    dl_next = dl_raw;
                end
            end
            ST_C_DL: begin
                rden_next = {(RDEN_W-3)'(dl_reg) * (RDEN_W-3)'(frac_sum), 3'b000};
            end
            ST_EVAL: begin
                if (err < DIVIDEND_W'(best_err_reg)) begin
                    best_err_next = err[BAUD_W-1:0];
                    dl_best_next  = dl_reg;
                    mul_best_next = mv_reg;
                    add_best_next = dav_reg;
                end
                if (last_pair) begin
                    mv_next  = mv_reg + 1'b1;
                    dav_next = '0;
                end else begin
                    dav_next = dav_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pclk_reg  <= PCLK_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                pclk_reg <= cfg_data;
            end
        end
        baud_reg     <= baud_next;
        mv_reg       <= mv_next;
        dav_reg      <= dav_next;
        pm_reg       <= pm_next;
        den_reg      <= den_next;
        wide_reg     <= wide_next;
        dl_reg       <= dl_next;
        rden_reg     <= rden_next;
        best_err_reg <= best_err_next;
        dl_best_reg  <= dl_best_next;
        mul_best_reg <= mul_best_next;
        add_best_reg <= add_best_next;
        unch_reg     <= unch_next;
    end

    fbd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tdata = {add_best_reg, mul_best_reg, dl_best_reg};
    assign m_tuser = unch_reg;

    // A new division is started only when the shared divider is free.
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The divider never sees a zero divisor.
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> div_req.divisor != '0)
        else $error("division by zero issued");

    // After an input transfer no further input is taken until the result leaves.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("input taken while an item is in progress");

    // A result always carries a usable fractional pair.
    a_frac_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:16] != 4'd0 && m_tdata[23:20] < m_tdata[19:16]))
        else $error("invalid fractional pair");

    // An unchanged result carries the fixed zero divisor.
    a_unchanged_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[15:0] == 16'd0)
        else $error("unchanged result with nonzero divisor");

endmodule

### rtl/fbd_div.sv
`timescale 1ns / 1ps

module fbd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  fbd_pkg::div_req_t req,
    output fbd_pkg::div_rsp_t rsp
);
    import fbd_pkg::*;

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;

    // Restoring division, one quotient bit per cycle. The dividend shifts out of
    // the top of quo_reg while quotient bits shift in at the bottom.
    always_comb begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIVISOR_W]) begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
